FILE: hw/rtl/fud_pkg.sv
// ----------------------------------------------------------------------------
// fud_pkg: shared types and decode functions
// Word types for the form body decoder, parser state, and the per-byte
// decode step that lists every result word one body byte produces.
// ----------------------------------------------------------------------------
package fud_pkg;

  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] Bom0      = 8'hEF;
  localparam logic [7:0] Bom1      = 8'hBB;
  localparam logic [7:0] Bom2      = 8'hBF;

  // worst case: '%' plus hex digit held behind two BOM bytes, then a
  // non-hex byte and stream end closing the pair
  localparam int MaxResults = 6;
  localparam int ResCntW    = $clog2(MaxResults + 1);

  // result queue depth: power of two, at least MaxResults
  localparam int QDepth = 8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_has_byte;
    logic       stream_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic       in_value_part;
    logic       pair_end;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic       section;
    logic [1:0] pend_count;
    logic [7:0] pend0;
    logic [7:0] pend1;
    logic [1:0] bom_count;
    logic [7:0] bom0;
    logic [7:0] bom1;
    logic       bom_resolved;
    logic       pair_open;
  } dec_state_t;

  typedef struct packed {
    dec_state_t                     st;
    logic [ResCntW-1:0]             cnt;
    out_word_t [MaxResults-1:0]     res;
  } dec_work_t;

  function automatic logic hex_ok(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    begin
      if (c <= 8'h39)      v = c - 8'h30;
      else if (c <= 8'h46) v = c - 8'h37;
      else                 v = c - 8'h57;
      return v[3:0];
    end
  endfunction

  function automatic logic [7:0] bom_at(logic [1:0] idx);
    logic [7:0] b;
    begin
      unique case (idx)
        2'd0:    b = Bom0;
        2'd1:    b = Bom1;
        default: b = Bom2;
      endcase
      return b;
    end
  endfunction

  function automatic dec_work_t put_word(dec_work_t w, out_word_t r);
    dec_work_t o;
    begin
      o = w;
      if (o.cnt < ResCntW'(MaxResults)) begin
        o.res[o.cnt] = r;
        o.cnt        = ResCntW'(o.cnt + 1'b1);
      end
      return o;
    end
  endfunction

  function automatic dec_work_t put_byte(dec_work_t w, logic [7:0] d);
    out_word_t r;
    begin
      r.out_byte      = d;
      r.out_has_byte  = 1'b1;
      r.in_value_part = w.st.section;
      r.pair_end      = 1'b0;
      r.last_of_run   = 1'b0;
      return put_word(w, r);
    end
  endfunction

  // holds back a possible EF BB BF at the start of a name or value
  function automatic dec_work_t bom_feed(dec_work_t w, logic [7:0] d);
    dec_work_t o;
    begin
      o = w;
      if (o.st.bom_resolved) begin
        o = put_byte(o, d);
      end else if (d == bom_at(o.st.bom_count)) begin
        if (o.st.bom_count == 2'd2) begin
          o.st.bom_count    = 2'd0;
          o.st.bom_resolved = 1'b1;
        end else if (o.st.bom_count == 2'd0) begin
          o.st.bom0      = d;
          o.st.bom_count = 2'd1;
        end else begin
          o.st.bom1      = d;
          o.st.bom_count = 2'd2;
        end
      end else begin
        if (o.st.bom_count != 2'd0) o = put_byte(o, o.st.bom0);
        if (o.st.bom_count == 2'd2) o = put_byte(o, o.st.bom1);
        o = put_byte(o, d);
        o.st.bom_count    = 2'd0;
        o.st.bom_resolved = 1'b1;
      end
      return o;
    end
  endfunction

  function automatic dec_work_t bom_flush(dec_work_t w);
    dec_work_t o;
    begin
      o = w;
      if (!o.st.bom_resolved) begin
        if (o.st.bom_count != 2'd0) o = put_byte(o, o.st.bom0);
        if (o.st.bom_count == 2'd2) o = put_byte(o, o.st.bom1);
      end
      o.st.bom_count    = 2'd0;
      o.st.bom_resolved = 1'b0;
      return o;
    end
  endfunction

  function automatic dec_work_t dec_char(dec_work_t w, logic [7:0] c);
    dec_work_t o;
    logic      done;
    begin
      o    = w;
      done = 1'b0;
      if (o.st.pend_count == 2'd1) begin
        if (hex_ok(c)) begin
          o.st.pend1      = c;
          o.st.pend_count = 2'd2;
          done            = 1'b1;
        end else begin
          o               = bom_feed(o, o.st.pend0);
          o.st.pend_count = 2'd0;
        end
      end else if (o.st.pend_count == 2'd2) begin
        if (hex_ok(c)) begin
          o               = bom_feed(o, {hex_val(o.st.pend1), hex_val(c)});
          o.st.pend_count = 2'd0;
          done            = 1'b1;
        end else begin
          o               = bom_feed(o, o.st.pend0);
          o               = bom_feed(o, o.st.pend1);
          o.st.pend_count = 2'd0;
        end
      end
      if (!done) begin
        if (c == CharPct) begin
          o.st.pend0      = c;
          o.st.pend_count = 2'd1;
        end else begin
          o = bom_feed(o, c);
        end
      end
      return o;
    end
  endfunction

  // unfinished escape goes out literally, then the BOM hold is released
  function automatic dec_work_t part_end(dec_work_t w);
    dec_work_t o;
    begin
      o = w;
      if (o.st.pend_count != 2'd0) o = bom_feed(o, o.st.pend0);
      if (o.st.pend_count == 2'd2) o = bom_feed(o, o.st.pend1);
      o.st.pend_count = 2'd0;
      o = bom_flush(o);
      return o;
    end
  endfunction

  function automatic dec_work_t put_pair_end(dec_work_t w);
    out_word_t r;
    begin
      r             = '0;
      r.pair_end    = 1'b1;
      return put_word(w, r);
    end
  endfunction

  function automatic dec_work_t dec_step(dec_state_t st, in_word_t iw);
    dec_work_t  o;
    logic [7:0] c;
    begin
      o    = '0;
      o.st = st;
      c    = (iw.in_byte == CharPlus) ? CharSpace : iw.in_byte;
      if (iw.in_has_byte) begin
        if (iw.in_byte == CharAmp) begin
          o = part_end(o);
          o = put_pair_end(o);
          o.st.section   = 1'b0;
          o.st.pair_open = 1'b0;
        end else if (iw.in_byte == CharEq && !o.st.section) begin
          o = part_end(o);
          o.st.section   = 1'b1;
          o.st.pair_open = 1'b1;
        end else begin
          o.st.pair_open = 1'b1;
          o = dec_char(o, c);
        end
      end
      if (iw.stream_end) begin
        if (o.st.pair_open) begin
          o = part_end(o);
          o = put_pair_end(o);
        end
        o.st = '0;
      end
      if (o.cnt != '0) o.res[ResCntW'(o.cnt - 1'b1)].last_of_run = 1'b1;
      return o;
    end
  endfunction

endpackage

FILE: hw/rtl/form_urlencoded_decoder_unit.sv
// ----------------------------------------------------------------------------
// form_urlencoded_decoder_unit: streaming form body decoder
// Latency: with the result queue empty, the first result word is valid the
// cycle after its byte is accepted.
// Throughput: one input word per cycle while the result queue holds at most
// two words; results, 0 to 6 per input word, go one per cycle if out_ready.
// Reset clears the parser state and empties the result queue.
// ----------------------------------------------------------------------------
module form_urlencoded_decoder_unit
  import fud_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  dec_state_t      state_r, state_nxt;
  dec_work_t       work;
  out_word_t       queue_r [QDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] push_n;
  logic            in_acc, out_acc;

  // room for a worst-case burst must be there before a word is taken
  assign in_ready  = (cnt_r <= CntW'(QDepth - MaxResults));
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_acc   = out_valid && out_ready;
  assign out_data  = queue_r[rd_ptr_r];

  always_comb begin
    work       = dec_step(state_r, in_data);
    state_nxt  = in_acc ? work.st : state_r;
    push_n     = in_acc ? CntW'(work.cnt) : '0;
    wr_ptr_nxt = PtrW'(wr_ptr_r + push_n);
    rd_ptr_nxt = out_acc ? PtrW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = CntW'(cnt_r + push_n - CntW'(out_acc));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MaxResults; k++) begin
      if (in_acc && (ResCntW'(k) < work.cnt)) begin
        queue_r[PtrW'(wr_ptr_r + PtrW'(k))] <= work.res[k];
      end
    end
  end

endmodule

FILE: bench/form_urlencoded_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// form_urlencoded_decoder_unit_tb: self-checking bench for the form decoder
// Walks a short table of hand-picked body bytes, then random form bodies
// (names, values, escapes, BOM prefixes, broken escapes, noise). A local
// decoder computes the result words of every accepted word; each output
// word is checked field by field. Both sides idle at random, and the result
// side holds off once for a long stretch to fill the block.
// ----------------------------------------------------------------------------
module form_urlencoded_decoder_unit_tb;
  import fud_pkg::*;

  localparam int CycLimit   = 600000;
  localparam int DrainWait  = 20;
  localparam int RandItems  = 400;
  localparam int MaxWords   = 8;

  typedef enum logic [1:0] {Predicted, Silent, Literal} chk_t;

  typedef struct packed {
    logic [7:0] b;
    logic       has;
    logic       fin;
    chk_t       chk;
    out_word_t  lit_w;
  } feed_row_t;

  localparam feed_row_t DirTab [27] = '{
    '{8'h00,    1'b0, 1'b0, Silent,    '0},
    '{CharAmp,  1'b1, 1'b0, Literal,   '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{8'hA5,    1'b0, 1'b1, Silent,    '0},
    '{8'h61,    1'b1, 1'b0, Literal,   '{8'h61, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{CharPlus, 1'b1, 1'b0, Literal,   '{CharSpace, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{CharEq,   1'b1, 1'b0, Predicted, '0},
    '{CharEq,   1'b1, 1'b0, Literal,   '{CharEq, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{CharPct,  1'b1, 1'b0, Predicted, '0},
    '{8'h34,    1'b1, 1'b0, Predicted, '0},
    '{8'h31,    1'b1, 1'b0, Predicted, '0},
    '{CharPct,  1'b1, 1'b0, Predicted, '0},
    '{8'h7A,    1'b1, 1'b0, Predicted, '0},
    '{CharPct,  1'b1, 1'b0, Predicted, '0},
    '{8'h65,    1'b1, 1'b0, Predicted, '0},
    '{CharAmp,  1'b1, 1'b0, Predicted, '0},
    '{CharPct,  1'b1, 1'b0, Predicted, '0},
    '{8'h45,    1'b1, 1'b0, Predicted, '0},
    '{8'h46,    1'b1, 1'b0, Predicted, '0},
    '{8'hBB,    1'b1, 1'b0, Predicted, '0},
    '{8'hBF,    1'b1, 1'b0, Predicted, '0},
    '{8'h00,    1'b1, 1'b0, Predicted, '0},
    '{CharEq,   1'b1, 1'b0, Predicted, '0},
    '{8'hEF,    1'b1, 1'b0, Predicted, '0},
    '{8'hBB,    1'b1, 1'b0, Predicted, '0},
    '{CharAmp,  1'b1, 1'b1, Predicted, '0},
    '{8'hFF,    1'b1, 1'b1, Predicted, '0},
    '{CharEq,   1'b1, 1'b1, Predicted, '0}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  form_urlencoded_decoder_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  feed_row_t body_q[$];
  out_word_t decoded_q[$];
  out_word_t run_q[$];
  int        errors = 0;
  int        rand_items = 0;
  int        cyc = 0;
  logic      calm = 1'b0;

  // decoder state
  logic       in_value;
  int         esc_n;
  logic [7:0] esc_hi;
  int         lead_n;
  logic [7:0] lead_b [2];
  logic       lead_done;
  logic       pair_live;

  function automatic void clear_state();
    in_value  = 1'b0;
    esc_n     = 0;
    esc_hi    = '0;
    lead_n    = 0;
    lead_b[0] = '0;
    lead_b[1] = '0;
    lead_done = 1'b0;
    pair_live = 1'b0;
  endfunction

  function automatic void emit(logic [7:0] b, logic has, logic val, logic pend);
    out_word_t w;
    if (run_q.size() >= MaxWords) return;
    w.out_byte      = b;
    w.out_has_byte  = has;
    w.in_value_part = val;
    w.pair_end      = pend;
    w.last_of_run   = 1'b0;
    run_q.push_back(w);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] nib(logic [7:0] c);
    return (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic logic [7:0] bom_byte(int i);
    return (i == 0) ? Bom0 : (i == 1) ? Bom1 : Bom2;
  endfunction

  // holds a possible EF BB BF at the start of a name or value
  function automatic void lead_feed(logic [7:0] d);
    if (lead_done) begin
      emit(d, 1'b1, in_value, 1'b0);
    end else if (d == bom_byte(lead_n)) begin
      if (lead_n == 2) begin
        lead_n    = 0;
        lead_done = 1'b1;
      end else begin
        lead_b[1'(lead_n)] = d;
        lead_n++;
      end
    end else begin
      for (int i = 0; i < lead_n; i++) emit(lead_b[1'(i)], 1'b1, in_value, 1'b0);
      emit(d, 1'b1, in_value, 1'b0);
      lead_n    = 0;
      lead_done = 1'b1;
    end
  endfunction

  function automatic void lead_flush();
    if (!lead_done)
      for (int i = 0; i < lead_n; i++) emit(lead_b[1'(i)], 1'b1, in_value, 1'b0);
    lead_n    = 0;
    lead_done = 1'b0;
  endfunction

  function automatic void decode_char(logic [7:0] c);
    if (esc_n == 1) begin
      if (is_hex(c)) begin
        esc_hi = c;
        esc_n  = 2;
        return;
      end
      lead_feed(CharPct);
      esc_n = 0;
    end else if (esc_n == 2) begin
      if (is_hex(c)) begin
        lead_feed({nib(esc_hi), nib(c)});
        esc_n = 0;
        return;
      end
      lead_feed(CharPct);
      lead_feed(esc_hi);
      esc_n = 0;
    end
    if (c == CharPct) esc_n = 1;
    else lead_feed(c);
  endfunction

  // open escape goes out as is, then the held prefix is released
  function automatic void close_part();
    if (esc_n >= 1) lead_feed(CharPct);
    if (esc_n == 2) lead_feed(esc_hi);
    esc_n = 0;
    lead_flush();
  endfunction

  function automatic void decode_word(in_word_t w);
    logic [7:0] c;
    out_word_t  tail;
    run_q.delete();
    c = (w.in_byte == CharPlus) ? CharSpace : w.in_byte;
    if (w.in_has_byte) begin
      if (w.in_byte == CharAmp) begin
        close_part();
        emit(8'h00, 1'b0, 1'b0, 1'b1);
        in_value  = 1'b0;
        pair_live = 1'b0;
      end else if (w.in_byte == CharEq && !in_value) begin
        close_part();
        in_value  = 1'b1;
        pair_live = 1'b1;
      end else begin
        pair_live = 1'b1;
        decode_char(c);
      end
    end
    if (w.stream_end) begin
      if (pair_live) begin
        close_part();
        emit(8'h00, 1'b0, 1'b0, 1'b1);
      end
      clear_state();
    end
    if (run_q.size() > 0) begin
      tail = run_q.pop_back();
      tail.last_of_run = 1'b1;
      run_q.push_back(tail);
    end
  endfunction

  // ---- random body generation ----
  function automatic void push(logic [7:0] b, logic has, logic fin);
    feed_row_t r;
    if ($urandom_range(0, 19) == 0) begin
      r = '{8'h00, 1'b0, 1'b0, Predicted, '0};
      body_q.push_back(r);
    end
    r = '{b, has, fin, Predicted, '0};
    body_q.push_back(r);
    if (has || fin) rand_items++;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 4'd10);
  endfunction

  function automatic logic [7:0] alnum();
    case ($urandom_range(0, 2))
      0:       return 8'h61 + 8'($urandom_range(0, 25));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h30 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic void push_escaped(logic [7:0] x);
    push(CharPct, 1'b1, 1'b0);
    push(hex_char(x[7:4]), 1'b1, 1'b0);
    push(hex_char(x[3:0]), 1'b1, 1'b0);
  endfunction

  function automatic void gen_part(logic is_val);
    int n;
    int toks;
    n = $urandom_range(1, 3);
    if ($urandom_range(0, 3) == 0)
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 1)) push_escaped(bom_byte(i));
        else push(bom_byte(i), 1'b1, 1'b0);
      end
    toks = $urandom_range(0, 5);
    for (int k = 0; k < toks; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: push(alnum(), 1'b1, 1'b0);
        3:       push(CharPlus, 1'b1, 1'b0);
        4, 5:    push_escaped(8'($urandom_range(0, 255)));
        6: begin
          // broken escape: '%' alone, or '%' and one digit, then maybe a non-hex byte
          push(CharPct, 1'b1, 1'b0);
          if ($urandom_range(0, 1)) push(hex_char(4'($urandom_range(0, 15))), 1'b1, 1'b0);
          if ($urandom_range(0, 2) != 0)
            push($urandom_range(0, 1) ? CharPct : 8'h67 + 8'($urandom_range(0, 19)),
                 1'b1, 1'b0);
        end
        7:       push(8'($urandom_range(128, 255)), 1'b1, 1'b0);
        8:       push(is_val ? CharEq : alnum(), 1'b1, 1'b0);
        default: push(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      endcase
    end
  endfunction

  function automatic void gen_body();
    int        npairs;
    int        n;
    feed_row_t r;
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(5, 15);
      for (int i = 0; i < n; i++)
        push(8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0,
             $urandom_range(0, 15) == 0);
      return;
    end
    npairs = $urandom_range(0, 4);
    for (int p = 0; p < npairs; p++) begin
      if ($urandom_range(0, 7) == 0) push(CharAmp, 1'b1, 1'b0);
      gen_part(1'b0);
      if ($urandom_range(0, 4) != 0) begin
        push(CharEq, 1'b1, 1'b0);
        gen_part(1'b1);
      end
      if (p != npairs - 1) push(CharAmp, 1'b1, 1'b0);
    end
    if ($urandom_range(0, 5) == 0) push(CharAmp, 1'b1, 1'b0);
    if (body_q.size() > 0 && $urandom_range(0, 1)) begin
      r = body_q.pop_back();
      r.fin = 1'b1;
      body_q.push_back(r);
    end else begin
      push(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void check_word(out_word_t got);
    out_word_t want;
    if (decoded_q.size() == 0) begin
      $error("unexpected word %h", got);
      errors++;
      return;
    end
    want = decoded_q.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte expected %h got %h", want.out_byte, got.out_byte);
      errors++;
    end
    if (got.out_has_byte !== want.out_has_byte) begin
      $error("out_has_byte expected %b got %b", want.out_has_byte, got.out_has_byte);
      errors++;
    end
    if (got.in_value_part !== want.in_value_part) begin
      $error("in_value_part expected %b got %b", want.in_value_part, got.in_value_part);
      errors++;
    end
    if (got.pair_end !== want.pair_end) begin
      $error("pair_end expected %b got %b", want.pair_end, got.pair_end);
      errors++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run expected %b got %b", want.last_of_run, got.last_of_run);
      errors++;
    end
  endfunction

  // ---- input side ----
  feed_row_t cur;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_word('{cur.b, cur.has, cur.fin});
        case (cur.chk)
          Predicted: foreach (run_q[i]) decoded_q.push_back(run_q[i]);
          Literal:   decoded_q.push_back(cur.lit_w);
          default:   ;
        endcase
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (body_q.size() > 0) begin
          cur = body_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= '{cur.b, cur.has, cur.fin};
          gap_left = calm ? 0 : pick_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- result side ----
  int   stall_left = 0;
  int   seen = 0;
  logic held = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_word(out_data);
        seen++;
      end
      // one long hold-off so the result queue fills and in_ready drops
      if (!held && seen >= 150) begin
        held = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = calm ? 0 : pick_idle();
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc % 150 == 0) calm <= ($urandom_range(0, 2) == 0);
    if (cyc > CycLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    clear_state();
    foreach (DirTab[i]) body_q.push_back(DirTab[i]);
    while (rand_items < RandItems) gen_body();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (body_q.size() != 0 || in_valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
